FILE: hw/rtl/wps_pkg.sv
package wps_pkg;

    localparam int unsigned NowW      = 32;
    localparam int unsigned DebounceW = 10;
    localparam int unsigned CircW     = 12;
    localparam int unsigned RpmW      = 16;
    localparam int unsigned SpeedW    = 21;
    localparam int unsigned CfgIdxW   = 1;
    localparam int unsigned CfgDataW  = 12;

    // One quotient bit per divider step; both numerators fit in SpeedW bits.
    localparam int unsigned DivSteps = SpeedW;
    localparam int unsigned CntW     = $clog2(DivSteps);

    localparam logic [SpeedW-1:0] MsPerMinute        = SpeedW'(60000);
    localparam logic [8:0]        CentiKmhPerMmPerMs = 9'd360;

    localparam logic [DebounceW-1:0] DebounceReset = DebounceW'(10);
    localparam logic [CircW-1:0]     CircReset     = CircW'(638);

    localparam logic [CfgIdxW-1:0] CfgDebounce = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgCirc     = 1'b1;

    localparam logic DivSelRpm   = 1'b0;
    localparam logic DivSelSpeed = 1'b1;

    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_sel;
        logic div_step;
        logic commit_rpm;
        logic commit_all;
        logic out_load;
    } t_wps_cmd;

    typedef struct packed {
        logic take;
        logic out_free;
    } t_wps_stat;

endpackage

FILE: hw/rtl/wps_ctrl.sv
module wps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wps_pkg::t_wps_stat i_stat,
    output wps_pkg::t_wps_cmd  o_cmd
);

    localparam logic [2:0] StIdle    = 3'd0;
    localparam logic [2:0] StDivRpm  = 3'd1;
    localparam logic [2:0] StNext    = 3'd2;
    localparam logic [2:0] StDivSpd  = 3'd3;
    localparam logic [2:0] StCommit  = 3'd4;
    localparam logic [2:0] StWrite   = 3'd5;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [wps_pkg::CntW-1:0] r_cnt;
    logic [wps_pkg::CntW-1:0] n_cnt;
    logic                    cnt_last;
    logic                    accept;

    assign o_ready  = (r_state == StIdle);
    assign accept   = o_ready && i_valid;
    assign cnt_last = (r_cnt == wps_pkg::CntW'(wps_pkg::DivSteps - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            StIdle: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    if (i_stat.take) begin
                        o_cmd.div_load = 1'b1;
                        o_cmd.div_sel  = wps_pkg::DivSelRpm;
                        n_state        = StDivRpm;
                    end else begin
                        n_state = StWrite;
                    end
                end
            end
            StDivRpm: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = StNext;
                end
            end
            StNext: begin
                o_cmd.commit_rpm = 1'b1;
                o_cmd.div_load   = 1'b1;
                o_cmd.div_sel    = wps_pkg::DivSelSpeed;
                n_state          = StDivSpd;
            end
            StDivSpd: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = StCommit;
                end
            end
            StCommit: begin
                o_cmd.commit_all = 1'b1;
                n_state          = StWrite;
            end
            StWrite: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/wps_dp.sv
module wps_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wps_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [wps_pkg::CfgDataW-1:0]      i_cfg_data,
    input  logic [wps_pkg::NowW-1:0]          i_now_ms,
    input  logic                              i_ready,
    input  wps_pkg::t_wps_cmd                 i_cmd,
    output wps_pkg::t_wps_stat                o_stat,
    output logic                              o_valid,
    output logic                              o_accepted,
    output logic [wps_pkg::NowW-1:0]          o_period_ms,
    output logic [wps_pkg::RpmW-1:0]          o_rpm,
    output logic [wps_pkg::SpeedW-1:0]        o_speed_centi_kmh,
    output logic [wps_pkg::NowW-1:0]          o_distance_mm
);

    logic [wps_pkg::DebounceW-1:0] r_debounce;
    logic [wps_pkg::CircW-1:0]     r_circ;

    logic [wps_pkg::NowW-1:0]   r_last;
    logic [wps_pkg::NowW-1:0]   r_held_period;
    logic [wps_pkg::RpmW-1:0]   r_held_rpm;
    logic [wps_pkg::SpeedW-1:0] r_held_speed;
    logic [wps_pkg::NowW-1:0]   r_dist;

    logic [wps_pkg::NowW-1:0]   r_now;
    logic [wps_pkg::NowW-1:0]   r_delta;
    logic                       r_take;
    logic [wps_pkg::SpeedW-1:0] r_spd_num;

    logic [wps_pkg::NowW-1:0]   r_rem;
    logic [wps_pkg::SpeedW-1:0] r_quo;

    logic                       r_out_valid;
    logic                       r_out_accepted;
    logic [wps_pkg::NowW-1:0]   r_out_period;
    logic [wps_pkg::RpmW-1:0]   r_out_rpm;
    logic [wps_pkg::SpeedW-1:0] r_out_speed;
    logic [wps_pkg::NowW-1:0]   r_out_dist;

    logic [wps_pkg::NowW-1:0]   delta;
    logic [wps_pkg::NowW:0]     rem_sh;
    logic [wps_pkg::NowW:0]     rem_diff;
    logic [wps_pkg::SpeedW-1:0] spd_num;

    assign delta    = i_now_ms - r_last;
    assign rem_sh   = {r_rem, r_quo[wps_pkg::SpeedW-1]};
    assign rem_diff = rem_sh - {1'b0, r_delta};
    assign spd_num  = wps_pkg::SpeedW'(r_circ) * wps_pkg::SpeedW'(wps_pkg::CentiKmhPerMmPerMs);

    assign o_stat.take     = (delta > wps_pkg::NowW'(r_debounce));
    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= wps_pkg::DebounceReset;
            r_circ     <= wps_pkg::CircReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wps_pkg::CfgDebounce: r_debounce <= i_cfg_data[wps_pkg::DebounceW-1:0];
                wps_pkg::CfgCirc:     r_circ     <= i_cfg_data[wps_pkg::CircW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now     <= i_now_ms;
            r_delta   <= delta;
            r_take    <= o_stat.take;
            r_spd_num <= spd_num;
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= (i_cmd.div_sel == wps_pkg::DivSelSpeed) ? r_spd_num : wps_pkg::MsPerMinute;
        end else if (i_cmd.div_step) begin
            if (!rem_diff[wps_pkg::NowW]) begin
                r_rem <= rem_diff[wps_pkg::NowW-1:0];
                r_quo <= {r_quo[wps_pkg::SpeedW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[wps_pkg::NowW-1:0];
                r_quo <= {r_quo[wps_pkg::SpeedW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last        <= '0;
            r_held_period <= '0;
            r_held_rpm    <= '0;
            r_held_speed  <= '0;
            r_dist        <= '0;
        end else begin
            if (i_cmd.commit_rpm) begin
                r_held_rpm <= r_quo[wps_pkg::RpmW-1:0];
            end
            if (i_cmd.commit_all) begin
                r_held_speed  <= r_quo;
                r_held_period <= r_delta;
                r_last        <= r_now;
                r_dist        <= r_dist + wps_pkg::NowW'(r_circ);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_accepted <= r_take;
            r_out_period   <= r_held_period;
            r_out_rpm      <= r_held_rpm;
            r_out_speed    <= r_held_speed;
            r_out_dist     <= r_dist;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_accepted        = r_out_accepted;
    assign o_period_ms       = r_out_period;
    assign o_rpm             = r_out_rpm;
    assign o_speed_centi_kmh = r_out_speed;
    assign o_distance_mm     = r_out_dist;

endmodule

FILE: hw/rtl/wheel_pulse_speedometer_core.sv
// Channel   Valid      Ready      Payload
// edge in   i_valid    o_ready    i_now_ms
// result    o_valid    i_ready    o_accepted, o_period_ms, o_rpm, o_speed_centi_kmh,
//                                 o_distance_mm
// config    i_cfg_we   (none)     i_cfg_idx, i_cfg_data
//
// An edge that passes debounce goes through one shared restoring divider, which
// produces one quotient bit per cycle and runs 21 steps for the RPM and then
// 21 steps for the speed.
// A rejected edge skips the divider and goes straight to the output write.
// Reset is synchronous, active low; payload, capture and divider registers are not reset.
// A result waits in the output register until taken, and the next request is
// accepted while it waits.
module wheel_pulse_speedometer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wps_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [wps_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wps_pkg::NowW-1:0]      i_now_ms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_accepted,
    output logic [wps_pkg::NowW-1:0]      o_period_ms,
    output logic [wps_pkg::RpmW-1:0]      o_rpm,
    output logic [wps_pkg::SpeedW-1:0]    o_speed_centi_kmh,
    output logic [wps_pkg::NowW-1:0]      o_distance_mm
);

    wps_pkg::t_wps_cmd  cmd;
    wps_pkg::t_wps_stat stat;

    wps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_now_ms          (i_now_ms),
        .i_ready           (i_ready),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_period_ms       (o_period_ms),
        .o_rpm             (o_rpm),
        .o_speed_centi_kmh (o_speed_centi_kmh),
        .o_distance_mm     (o_distance_mm)
    );

endmodule
